// ----- src/bcdep_pkg.sv -----
// Shared types, widths and lookup functions for the BCD clock to epoch
// seconds converter. No dependencies; used by every module in src.
`default_nettype none

package bcdep_pkg;

  // Widths of the decoded fields (largest value from the masked BCD byte).
  localparam int unsigned SecW   = 7;   // up to 85
  localparam int unsigned HourW  = 6;   // up to 45
  localparam int unsigned MonW   = 5;   // shifted month, 1 to 23
  localparam int unsigned YearW  = 8;   // year minus 1999, 0 to 166
  localparam int unsigned DaysW  = 17;  // day count since 1970, below 2^17
  localparam int unsigned DhW    = 22;  // days * 24 + hour
  localparam int unsigned DmW    = 28;  // (days * 24 + hour) * 60 + min
  localparam int unsigned EpochW = 32;

  // Day count base: 365*1999 + 1999/4 - 719499, folded with the century terms.
  localparam logic [DaysW-1:0] DayBaseLo = DaysW'(10620);  // years 1999..2099
  localparam logic [DaysW-1:0] DayBaseHi = DaysW'(10619);  // years 2100 and up
  localparam logic [YearW-1:0] YearOff2100 = YearW'(101);

  // One snapshot after BCD decode and month shift.
  typedef struct packed {
    logic [SecW-1:0]  sec;
    logic [SecW-1:0]  min;
    logic [HourW-1:0] hour;
    logic [HourW-1:0] day;
    logic [MonW-1:0]  mon;
    logic [YearW-1:0] year;
  } dec_t;

  // Load enables for the time accumulation stages.
  typedef struct packed {
    logic dh;
    logic dm;
    logic tot;
  } sec_en_t;

  // Decode one masked BCD byte as tens * 10 + units; bad digits pass as is.
  function automatic logic [7:0] bcd_val(input logic [7:0] b);
    logic [7:0] tens;
    tens = {4'b0000, b[7:4]};
    return (tens << 3) + (tens << 1) + {4'b0000, b[3:0]};
  endfunction

  // Days before the start of a shifted month: (367 * m) / 12.
  function automatic logic [9:0] mon_days(input logic [MonW-1:0] m);
    logic [9:0] d;
    unique case (m)
      5'd1:    d = 10'd30;
      5'd2:    d = 10'd61;
      5'd3:    d = 10'd91;
      5'd4:    d = 10'd122;
      5'd5:    d = 10'd152;
      5'd6:    d = 10'd183;
      5'd7:    d = 10'd214;
      5'd8:    d = 10'd244;
      5'd9:    d = 10'd275;
      5'd10:   d = 10'd305;
      5'd11:   d = 10'd336;
      5'd12:   d = 10'd367;
      5'd13:   d = 10'd397;
      5'd14:   d = 10'd428;
      5'd15:   d = 10'd458;
      5'd16:   d = 10'd489;
      5'd17:   d = 10'd519;
      5'd18:   d = 10'd550;
      5'd19:   d = 10'd581;
      5'd20:   d = 10'd611;
      5'd21:   d = 10'd642;
      5'd22:   d = 10'd672;
      5'd23:   d = 10'd703;
      default: d = 10'd0;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

// ----- src/bcdep_decode.sv -----
// First pipeline stage: masks and decodes the six BCD bytes and shifts the
// month so the year starts in March. Depends on bcdep_pkg.
`default_nettype none

module bcdep_decode import bcdep_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       en_i,
  input  wire logic [7:0] sec_bcd_i,
  input  wire logic [7:0] min_bcd_i,
  input  wire logic [7:0] hour_bcd_i,
  input  wire logic [7:0] day_bcd_i,
  input  wire logic [7:0] month_bcd_i,
  input  wire logic [7:0] year_bcd_i,
  output dec_t            dec_o
);

  logic [7:0] mon_raw;
  logic [7:0] year_raw;
  logic [7:0] sec_raw;
  logic [7:0] min_raw;
  logic [7:0] hour_raw;
  logic [7:0] day_raw;
  logic       early;
  dec_t       dec_d;
  dec_t       dec_q;

  // Mask each byte to its field and decode.
  always_comb begin
    sec_raw  = bcd_val(sec_bcd_i   & 8'h7F);
    min_raw  = bcd_val(min_bcd_i   & 8'h7F);
    hour_raw = bcd_val(hour_bcd_i  & 8'h3F);
    day_raw  = bcd_val(day_bcd_i   & 8'h3F);
    mon_raw  = bcd_val(month_bcd_i & 8'h1F);
    year_raw = bcd_val(year_bcd_i);
  end

  // January, February (and month zero) count as the tail of the year before.
  always_comb begin
    early     = (mon_raw <= 8'd2);
    dec_d.sec  = sec_raw[SecW-1:0];
    dec_d.min  = min_raw[SecW-1:0];
    dec_d.hour = hour_raw[HourW-1:0];
    dec_d.day  = day_raw[HourW-1:0];
    dec_d.mon  = early ? MonW'(mon_raw + 8'd10) : MonW'(mon_raw - 8'd2);
    // Year relative to 1999.
    dec_d.year = early ? year_raw : (year_raw + 8'd1);
  end

  // Hold while the next stage is blocked.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dec_q <= dec_d;
    end
  end

  assign dec_o = dec_q;

endmodule

`default_nettype wire

// ----- src/bcdep_days.sv -----
// Second pipeline stage: turns the decoded date into a day count since
// 1970-01-01 and carries the time of day along. Depends on bcdep_pkg.
`default_nettype none

module bcdep_days import bcdep_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              en_i,
  input  wire dec_t              dec_i,
  output logic [DaysW-1:0]       days_o,
  output logic [HourW-1:0]       hour_o,
  output logic [SecW-1:0]        min_o,
  output logic [SecW-1:0]        sec_o
);

  logic [DaysW-1:0] yr_days;
  logic [DaysW-1:0] leap;
  logic [DaysW-1:0] base;
  logic [DaysW-1:0] days_d;
  logic [DaysW-1:0] days_q;
  logic [HourW-1:0] hour_q;
  logic [SecW-1:0]  min_q;
  logic [SecW-1:0]  sec_q;
  logic [YearW:0]   yp3;

  // 365 * year + leap days + month start + day of month + base.
  always_comb begin
    yr_days = (DaysW'(dec_i.year) << 8) + (DaysW'(dec_i.year) << 6)
            + (DaysW'(dec_i.year) << 5) + (DaysW'(dec_i.year) << 3)
            + (DaysW'(dec_i.year) << 2) + DaysW'(dec_i.year);
    yp3     = {1'b0, dec_i.year} + (YearW+1)'(3);
    leap    = DaysW'(yp3 >> 2);
    base    = (dec_i.year >= YearOff2100) ? DayBaseHi : DayBaseLo;
    days_d  = yr_days + leap + DaysW'(mon_days(dec_i.mon)) + DaysW'(dec_i.day) + base;
  end

  // Hold while the next stage is blocked.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      days_q <= days_d;
      hour_q <= dec_i.hour;
      min_q  <= dec_i.min;
      sec_q  <= dec_i.sec;
    end
  end

  assign days_o = days_q;
  assign hour_o = hour_q;
  assign min_o  = min_q;
  assign sec_o  = sec_q;

endmodule

`default_nettype wire

// ----- src/bcdep_secs.sv -----
// Third to fifth pipeline stages: scale days to hours, minutes and seconds
// with shift-add constant multiplies, modulo 2^32. Depends on bcdep_pkg.
`default_nettype none

module bcdep_secs import bcdep_pkg::*; (
  input  wire logic              clk_i,
  input  wire sec_en_t           en_i,
  input  wire logic [DaysW-1:0]  days_i,
  input  wire logic [HourW-1:0]  hour_i,
  input  wire logic [SecW-1:0]   min_i,
  input  wire logic [SecW-1:0]   sec_i,
  output logic [EpochW-1:0]      tot_o
);

  logic [DhW-1:0]    dh_d;
  logic [DhW-1:0]    dh_q;
  logic [SecW-1:0]   min_q;
  logic [SecW-1:0]   sec_q;
  logic [DmW-1:0]    dm_d;
  logic [DmW-1:0]    dm_q;
  logic [SecW-1:0]   sec2_q;
  logic [EpochW-1:0] tot_d;
  logic [EpochW-1:0] tot_q;

  // Hours: days * 24 + hour.
  assign dh_d = (DhW'(days_i) << 4) + (DhW'(days_i) << 3) + DhW'(hour_i);

  always_ff @(posedge clk_i) begin
    if (en_i.dh) begin
      dh_q  <= dh_d;
      min_q <= min_i;
      sec_q <= sec_i;
    end
  end

  // Minutes: hours * 60 + min.
  assign dm_d = (DmW'(dh_q) << 6) - (DmW'(dh_q) << 2) + DmW'(min_q);

  always_ff @(posedge clk_i) begin
    if (en_i.dm) begin
      dm_q   <= dm_d;
      sec2_q <= sec_q;
    end
  end

  // Seconds: minutes * 60 + sec, wrapping at 32 bits.
  assign tot_d = (EpochW'(dm_q) << 6) - (EpochW'(dm_q) << 2) + EpochW'(sec2_q);

  always_ff @(posedge clk_i) begin
    if (en_i.tot) begin
      tot_q <= tot_d;
    end
  end

  assign tot_o = tot_q;

endmodule

`default_nettype wire

// ----- src/bcd_clock_to_epoch_seconds_top.sv -----
// Top level of the BCD clock to epoch seconds converter: handshake, offset
// register and output stage. Depends on bcdep_pkg, bcdep_decode, bcdep_days
// and bcdep_secs.
`default_nettype none

// Converts one snapshot of six BCD clock bytes (year 2000-2099) into Unix
// epoch seconds plus the signed time_offset register, modulo 2^32. The
// datapath is a six-stage pipeline (decode, day count, hours, minutes,
// seconds, offset add), and a new word can be accepted every cycle while
// the output is not stalled. Stalls on the output back up stage by stage;
// empty stages still take new words. Out-of-range or invalid BCD digits
// are not checked and feed the formula linearly. The offset port is always
// ready; write it only while the pipeline is empty.
module bcd_clock_to_epoch_seconds_top import bcdep_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // input words
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [7:0]        sec_bcd_i,
  input  wire logic [7:0]        min_bcd_i,
  input  wire logic [7:0]        hour_bcd_i,
  input  wire logic [7:0]        day_bcd_i,
  input  wire logic [7:0]        month_bcd_i,
  input  wire logic [7:0]        year_bcd_i,
  // output words
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [EpochW-1:0]      epoch_seconds_o,
  // offset register write
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [EpochW-1:0] cfg_data_i
);

  localparam int unsigned NumStages = 6;

  logic [NumStages-1:0] vld_q;
  logic [NumStages-1:0] adv;
  logic [EpochW-1:0]    offset_q;
  logic [EpochW-1:0]    epoch_q;
  dec_t                 dec;
  logic [DaysW-1:0]     days;
  logic [HourW-1:0]     hour;
  logic [SecW-1:0]      min;
  logic [SecW-1:0]      sec;
  logic [EpochW-1:0]    tot;
  sec_en_t              sec_en;

  // A stage advances when it is empty or the stage after it advances.
  always_comb begin
    adv[NumStages-1] = !vld_q[NumStages-1] || !out_stall_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  assign in_stall_o = !adv[0];

  // Move valid bits along with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (adv[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // Offset register; always ready.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
    end else if (cfg_valid_i) begin
      offset_q <= cfg_data_i;
    end
  end

  bcdep_decode u_decode (
    .clk_i       (clk_i),
    .en_i        (adv[0]),
    .sec_bcd_i   (sec_bcd_i),
    .min_bcd_i   (min_bcd_i),
    .hour_bcd_i  (hour_bcd_i),
    .day_bcd_i   (day_bcd_i),
    .month_bcd_i (month_bcd_i),
    .year_bcd_i  (year_bcd_i),
    .dec_o       (dec)
  );

  bcdep_days u_days (
    .clk_i  (clk_i),
    .en_i   (adv[1]),
    .dec_i  (dec),
    .days_o (days),
    .hour_o (hour),
    .min_o  (min),
    .sec_o  (sec)
  );

  assign sec_en.dh  = adv[2];
  assign sec_en.dm  = adv[3];
  assign sec_en.tot = adv[4];

  bcdep_secs u_secs (
    .clk_i  (clk_i),
    .en_i   (sec_en),
    .days_i (days),
    .hour_i (hour),
    .min_i  (min),
    .sec_i  (sec),
    .tot_o  (tot)
  );

  // Add the offset into the output register; hold while stalled.
  always_ff @(posedge clk_i) begin
    if (adv[NumStages-1]) begin
      epoch_q <= tot + offset_q;
    end
  end

  assign out_valid_o     = vld_q[NumStages-1];
  assign epoch_seconds_o = epoch_q;

endmodule

`default_nettype wire
